[src/etfr_pkg.sv]
// Shared types, constants and the decade step table of the tuned frequency register.
package etfr_pkg;

   localparam int FREQ_W  = 26;
   localparam int STEP_W  = 3;
   localparam int PINS_W  = 2;
   localparam int SUM_W   = FREQ_W + 2;

   localparam int STEP_COUNT = 7;

   localparam logic [STEP_W:0]   STEP_LIMIT     = (STEP_W + 1)'(STEP_COUNT);
   localparam logic [FREQ_W-1:0] START_FREQUENCY = FREQ_W'(7000000);
   localparam logic [FREQ_W-1:0] MAX_FREQ_RESET  = FREQ_W'(40000000);

   // Encoder pin codes; a detent counts only when leaving the idle code.
   localparam logic [PINS_W-1:0] PINS_IDLE = 2'b00;
   localparam logic [PINS_W-1:0] PINS_DOWN = 2'b01;
   localparam logic [PINS_W-1:0] PINS_UP   = 2'b10;

   // Step size in hertz for each step index.
   localparam logic [FREQ_W-1:0] STEP_SIZE [2**STEP_W] = '{
      FREQ_W'(1), FREQ_W'(10), FREQ_W'(100), FREQ_W'(1000),
      FREQ_W'(10000), FREQ_W'(100000), FREQ_W'(1000000), FREQ_W'(10000000)
   };

   typedef struct packed {
      logic [PINS_W-1:0] pins;
      logic              press;
   } item_type;

   // Hand-off from the input stage to the tuning core.
   typedef struct packed {
      logic     advance;
      item_type item;
   } handoff_type;

   typedef struct packed {
      logic [FREQ_W-1:0] frequency;
      logic [STEP_W-1:0] step;
      logic              refresh;
   } result_type;

endpackage

[src/etfr_in_stage.sv]
// Input register of the tuned frequency register with its flow control.
module etfr_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  etfr_pkg::item_type req_item,
   input  logic               rsp_valid_ff,
   input  logic               rsp_stall,
   output etfr_pkg::handoff_type handoff
);
   import etfr_pkg::*;

   logic     in_valid_ff, in_valid_in;
   item_type item_ff, item_in;
   logic     advance;
   logic     accept;

   // The held transaction moves on when the result register is free or is being taken.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         item_in     = req_item;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign handoff.advance = advance;
   assign handoff.item    = item_ff;

`ifndef SYNTHESIS
   a_stall_needs_item : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stall raised without a blocked transaction");
`endif

endmodule

[src/etfr_tune_core.sv]
// Step selection, encoder decode, frequency update and clamp with their state registers.
module etfr_tune_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [etfr_pkg::FREQ_W-1:0] csr_wr_data,
   input  etfr_pkg::handoff_type       handoff,
   output etfr_pkg::result_type        result
);
   import etfr_pkg::*;

   logic [FREQ_W-1:0] tuned_ff, tuned_in;
   logic [FREQ_W-1:0] last_ff, last_in;
   logic [PINS_W-1:0] prev_pins_ff, prev_pins_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [FREQ_W-1:0] max_freq_ff, max_freq_in;

   logic [STEP_W-1:0]       step_inc;
   logic                    move_up, move_down;
   logic [FREQ_W-1:0]       size;
   logic signed [SUM_W-1:0] sum;
   logic                    changed;
   logic [FREQ_W-1:0]       clamped;

   always_comb begin
      step_inc = step_ff + STEP_W'(1);
      step_in  = step_ff;
      if (handoff.item.press) begin
         step_in = ({1'b0, step_inc} >= STEP_LIMIT) ? '0 : step_inc;
      end

      move_up   = (prev_pins_ff == PINS_IDLE) && (handoff.item.pins == PINS_UP);
      move_down = (prev_pins_ff == PINS_IDLE) && (handoff.item.pins == PINS_DOWN);
      size      = STEP_SIZE[step_in];

      sum = $signed({2'b00, tuned_ff});
      if (move_up) begin
         sum = $signed({2'b00, tuned_ff}) + $signed({2'b00, size});
      end else if (move_down) begin
         sum = $signed({2'b00, tuned_ff}) - $signed({2'b00, size});
      end

      changed = (sum != $signed({2'b00, last_ff}));

      if (sum < 0) begin
         clamped = '0;
      end else if (sum >= $signed({2'b00, max_freq_ff})) begin
         clamped = max_freq_ff;
      end else begin
         clamped = sum[FREQ_W-1:0];
      end

      tuned_in     = changed ? clamped : tuned_ff;
      last_in      = changed ? clamped : last_ff;
      prev_pins_in = handoff.item.pins;
      max_freq_in  = csr_wr_en ? csr_wr_data : max_freq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tuned_ff     <= START_FREQUENCY;
         last_ff      <= '0;
         prev_pins_ff <= PINS_IDLE;
         step_ff      <= '0;
         max_freq_ff  <= MAX_FREQ_RESET;
      end else begin
         max_freq_ff <= max_freq_in;
         if (handoff.advance) begin
            tuned_ff     <= tuned_in;
            last_ff      <= last_in;
            prev_pins_ff <= prev_pins_in;
            step_ff      <= step_in;
         end
      end
   end

   assign result.frequency = tuned_in;
   assign result.step      = step_in;
   assign result.refresh   = handoff.item.press || changed;

`ifndef SYNTHESIS
   a_press_moves_step : assert property (@(posedge clock) disable iff (reset)
      handoff.advance && handoff.item.press |=> step_ff != $past(step_ff))
      else $error("step press did not change the step index");

   a_quiet_holds_freq : assert property (@(posedge clock) disable iff (reset)
      handoff.advance && !result.refresh |=> tuned_ff == $past(tuned_ff))
      else $error("frequency changed without a refresh");
`endif

endmodule

[src/encoder_tuned_frequency_register_unit.sv]
// Top level of the encoder tuned frequency register: input stage, tuning core, result register.
//
// This block turns polls of a quadrature tuning knob into a tuned frequency in hertz.
// Every request transaction carries the two encoder pin levels and a step button press
// event, and produces exactly one response transaction with the frequency, the step
// index and a refresh flag. A press advances the step index through 0 to 6 and wraps;
// the step size is ten to the power of the index. A detent counts only when the pins
// leave the idle code 00: going to 01 steps down, going to 10 steps up, using the step
// size selected in the same poll. The result is clamped between zero and the maximum
// frequency held in the configuration register (reset value 40 MHz); the frequency
// starts at 7 MHz. Refresh is high when the step changed or the unclamped frequency
// differs from the last stored frequency, so the first poll after reset always
// refreshes. Throughput is one transaction per clock while the response side does not
// stall: a request is captured in the input register, then the combinational tuning logic
// (one 28-bit add and the clamp compare) updates the state and loads the response register
// when that register is free or being taken. The input stage keeps accepting while a
// response waits, and stalls only when both registers are full and the response side
// stalls. Write the maximum frequency only while the block is idle.
module encoder_tuned_frequency_register_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [etfr_pkg::PINS_W-1:0] req_encoder_pins,
   input  logic                        req_step_press,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [etfr_pkg::FREQ_W-1:0] rsp_frequency_hz,
   output logic [etfr_pkg::STEP_W-1:0] rsp_step_index,
   output logic                        rsp_refresh,
   input  logic                        csr_wr_en,
   input  logic [etfr_pkg::FREQ_W-1:0] csr_wr_data
);
   import etfr_pkg::*;

   item_type    req_item;
   handoff_type handoff;
   result_type  result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   assign req_item.pins  = req_encoder_pins;
   assign req_item.press = req_step_press;

   // Input register and its flow control.
   etfr_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .rsp_valid_ff (rsp_valid_ff),
      .rsp_stall    (rsp_stall),
      .handoff      (handoff)
   );

   // Tuning state and the combinational update for one transaction.
   etfr_tune_core u_tune_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .handoff     (handoff),
      .result      (result)
   );

   // The response register loads whenever a transaction advances out of the input stage;
   // otherwise it empties once its content has been taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (handoff.advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frequency_hz = rsp_data_ff.frequency;
   assign rsp_step_index   = rsp_data_ff.step;
   assign rsp_refresh      = rsp_data_ff.refresh;

`ifndef SYNTHESIS
   a_step_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_step_index} < STEP_LIMIT)
      else $error("response step index out of range");
`endif

endmodule
